// File: rtl/gn3_pkg.sv
// Shared types, constants and the fixed permutation table for the gradient noise unit.
package gn3_pkg;

	localparam int GN3_TABLE_SIZE = 256;
	localparam int GN3_IDX_W      = $clog2(GN3_TABLE_SIZE);
	localparam int GN3_FRAC_BITS  = 16;
	localparam int GN3_QDEPTH     = 4;
	localparam int GN3_DOT_W      = 36;

	// Fixed hash permutation
	localparam logic [7:0] GN3_PERM [GN3_TABLE_SIZE] = '{
		8'd225,8'd155,8'd210,8'd108,8'd175,8'd199,8'd221,8'd144,
		8'd203,8'd116,8'd70,8'd213,8'd69,8'd158,8'd33,8'd252,
		8'd5,8'd82,8'd173,8'd133,8'd222,8'd139,8'd174,8'd27,
		8'd9,8'd71,8'd90,8'd246,8'd75,8'd130,8'd91,8'd191,
		8'd169,8'd138,8'd2,8'd151,8'd194,8'd235,8'd81,8'd7,
		8'd25,8'd113,8'd228,8'd159,8'd205,8'd253,8'd134,8'd142,
		8'd248,8'd65,8'd224,8'd217,8'd22,8'd121,8'd229,8'd63,
		8'd89,8'd103,8'd96,8'd104,8'd156,8'd17,8'd201,8'd129,
		8'd36,8'd8,8'd165,8'd110,8'd237,8'd117,8'd231,8'd56,
		8'd132,8'd211,8'd152,8'd20,8'd181,8'd111,8'd239,8'd218,
		8'd170,8'd163,8'd51,8'd172,8'd157,8'd47,8'd80,8'd212,
		8'd176,8'd250,8'd87,8'd49,8'd99,8'd242,8'd136,8'd189,
		8'd162,8'd115,8'd44,8'd43,8'd124,8'd94,8'd150,8'd16,
		8'd141,8'd247,8'd32,8'd10,8'd198,8'd223,8'd255,8'd72,
		8'd53,8'd131,8'd84,8'd57,8'd220,8'd197,8'd58,8'd50,
		8'd208,8'd11,8'd241,8'd28,8'd3,8'd192,8'd62,8'd202,
		8'd18,8'd215,8'd153,8'd24,8'd76,8'd41,8'd15,8'd179,
		8'd39,8'd46,8'd55,8'd6,8'd128,8'd167,8'd23,8'd188,
		8'd106,8'd34,8'd187,8'd140,8'd164,8'd73,8'd112,8'd182,
		8'd244,8'd195,8'd227,8'd13,8'd35,8'd77,8'd196,8'd185,
		8'd26,8'd200,8'd226,8'd119,8'd31,8'd123,8'd168,8'd125,
		8'd249,8'd68,8'd183,8'd230,8'd177,8'd135,8'd160,8'd180,
		8'd12,8'd1,8'd243,8'd148,8'd102,8'd166,8'd38,8'd238,
		8'd251,8'd37,8'd240,8'd126,8'd64,8'd74,8'd161,8'd40,
		8'd184,8'd149,8'd171,8'd178,8'd101,8'd66,8'd29,8'd59,
		8'd146,8'd61,8'd254,8'd107,8'd42,8'd86,8'd154,8'd4,
		8'd236,8'd232,8'd120,8'd21,8'd233,8'd209,8'd45,8'd98,
		8'd193,8'd114,8'd78,8'd19,8'd206,8'd14,8'd118,8'd127,
		8'd48,8'd79,8'd147,8'd85,8'd30,8'd207,8'd219,8'd54,
		8'd88,8'd234,8'd190,8'd122,8'd95,8'd67,8'd143,8'd109,
		8'd137,8'd214,8'd145,8'd93,8'd92,8'd100,8'd245,8'd0,
		8'd216,8'd186,8'd60,8'd83,8'd105,8'd97,8'd204,8'd52};

	typedef enum logic {
		FUNC_EVAL = 1'b0,
		FUNC_LOAD = 1'b1
	} func_t;

	// One classified word as held in the queue
	typedef struct packed {
		func_t                 func;
		logic [GN3_IDX_W-1:0]  cell_x;
		logic [GN3_IDX_W-1:0]  cell_y;
		logic [GN3_IDX_W-1:0]  cell_z;
		logic [15:0]           frac_x;
		logic [15:0]           frac_y;
		logic [15:0]           frac_z;
		logic [GN3_IDX_W-1:0]  slot;
		logic signed [15:0]    gx;
		logic signed [15:0]    gy;
		logic signed [15:0]    gz;
	} item_t;

	function automatic logic [7:0] perm(input logic [GN3_IDX_W-1:0] i);
		return GN3_PERM[i];
	endfunction

endpackage

// File: rtl/gradient_noise_3d_unit.sv
// Top level of the 3-D gradient noise unit.
// Throughput: one word per cycle while the output is not held, loads and evaluates alike; set by the 16-stage
// evaluation pipeline with four dual-read copies of the gradient table.
// A 4-entry queue lets the input side keep accepting while the output stalls, until the queue is full.
// Reset clears all control state; the gradient table is undefined until loaded.
module gradient_noise_3d_unit #(
	parameter int FRAC_BITS = gn3_pkg::GN3_FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// x_coord, y_coord, z_coord, grad_slot, grad_x, grad_y, grad_z (from bit 0 up)
	input  logic [151:0]  s_axis_tdata,
	// func
	input  logic          s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// noise_value
	output logic [15:0]   m_axis_tdata
);
	import gn3_pkg::*;

	logic   q_full, q_empty, push, pop;
	item_t  push_item, head_item;

	gn3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	gn3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head_item (head_item)
	);

	logic back_ready;
	assign pop = back_ready && !q_empty;

	gn3_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (!q_empty),
		.in_ready      (back_ready),
		.in_item       (head_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// File: rtl/gn3_front.sv
// Input side: accepts words, splits coordinates into lattice cell and fraction.
module gn3_front #(
	parameter int FRAC_BITS = gn3_pkg::GN3_FRAC_BITS
) (
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// x_coord, y_coord, z_coord, grad_slot, grad_x, grad_y, grad_z (from bit 0 up)
	input  logic [151:0]       s_axis_tdata,
	// func
	input  logic               s_axis_tuser,
	input  logic               q_full,
	output logic               push,
	output gn3_pkg::item_t     push_item
);
	import gn3_pkg::*;

	logic [31:0]          coord [3];
	logic [GN3_IDX_W-1:0] lat   [3];
	logic [15:0]          frac  [3];

	assign coord[0] = s_axis_tdata[31:0];
	assign coord[1] = s_axis_tdata[63:32];
	assign coord[2] = s_axis_tdata[95:64];

	// Split each coordinate; fraction brought to Q0.16
	for (genvar i = 0; i < 3; i++) begin : g_split
		assign lat[i] = coord[i][FRAC_BITS +: GN3_IDX_W];
		if (FRAC_BITS >= 16) begin : g_trunc
			assign frac[i] = coord[i][FRAC_BITS-1 -: 16];
		end else begin : g_widen
			assign frac[i] = {coord[i][FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
		end
	end

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	always_comb begin
		push_item.func   = s_axis_tuser ? FUNC_LOAD : FUNC_EVAL;
		push_item.cell_x = lat[0];
		push_item.cell_y = lat[1];
		push_item.cell_z = lat[2];
		push_item.frac_x = frac[0];
		push_item.frac_y = frac[1];
		push_item.frac_z = frac[2];
		push_item.slot   = s_axis_tdata[103:96];
		push_item.gx     = s_axis_tdata[119:104];
		push_item.gy     = s_axis_tdata[135:120];
		push_item.gz     = s_axis_tdata[151:136];
	end

endmodule

// File: rtl/gn3_queue.sv
// Short FIFO between the input side and the evaluation pipeline.
module gn3_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gn3_pkg::item_t  push_item,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output gn3_pkg::item_t  head_item
);
	import gn3_pkg::*;

	localparam int PW = $clog2(GN3_QDEPTH);
	localparam int CW = $clog2(GN3_QDEPTH + 1);

	item_t           buf_q [GN3_QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full      = (cnt_q == CW'(GN3_QDEPTH));
	assign empty     = (cnt_q == '0);
	assign head_item = buf_q[rd_ptr_q];

	// Storage, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("fill count lost a push");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(GN3_QDEPTH)) else $error("fill count beyond depth");
`endif

endmodule

// File: rtl/gn3_back.sv
// Evaluation pipeline: hashing, gradient table, dot products, smooth blend.
module gn3_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gn3_pkg::item_t  in_item,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	// noise_value
	output logic [15:0]     m_axis_tdata
);
	import gn3_pkg::*;

	localparam int DW = GN3_DOT_W;
	localparam int NS = 16;

	logic en;
	logic vld_q [1:NS];

	// Stage registers
	item_t                 it_s1, it_s2, it_s3, it_s4;
	logic [7:0]            pz_s1 [2];
	logic [31:0]           ff_s1 [3];
	logic [7:0]            py_s2 [4];
	logic [GN3_IDX_W-1:0]  h_s3  [8];
	logic [47:0]           g_s4  [8];
	logic signed [32:0]    prod_s5 [8][3];
	logic signed [DW-1:0]  dot_s6 [8];
	logic signed [DW-1:0]  a_s7 [4], d_s7 [4];
	logic signed [DW-1:0]  a_s8 [4];
	logic signed [52:0]    m_s8 [4];
	logic signed [DW-1:0]  y_s9 [4];
	logic signed [DW-1:0]  a_s10 [2], d_s10 [2];
	logic signed [DW-1:0]  a_s11 [2];
	logic signed [52:0]    m_s11 [2];
	logic signed [DW-1:0]  z_s12 [2];
	logic signed [DW-1:0]  a_s13, d_s13, a_s14;
	logic signed [52:0]    m_s14;
	logic signed [DW-1:0]  v_s15;
	logic [15:0]           out_s16;
	logic [2:0][15:0]      w_pipe_q [2:13];

	logic [15:0]           fr  [3];
	logic [15:0]           w_c [3];
	logic                  wr_en;
	logic signed [DW-1:0]  rnd;
	logic signed [19:0]    rq;

	// Whole pipeline advances unless the output word is held
	assign en            = !vld_q[NS] || m_axis_tready;
	assign in_ready      = en;
	assign m_axis_tvalid = vld_q[NS];
	assign m_axis_tdata  = out_s16;

	assign fr[0] = it_s1.frac_x;
	assign fr[1] = it_s1.frac_y;
	assign fr[2] = it_s1.frac_z;

	// Smooth weight 3f^2-2f^3, second multiply
	for (genvar i = 0; i < 3; i++) begin : g_w
		logic [49:0] wp;
		assign wp     = ff_s1[i] * (18'd196608 - {1'b0, fr[i], 1'b0});
		assign w_c[i] = wp[47:32];
	end

	// Valid chain; loads drop out after the table stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NS; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (en) begin
			vld_q[1] <= in_valid;
			vld_q[2] <= vld_q[1];
			vld_q[3] <= vld_q[2];
			vld_q[4] <= vld_q[3] && (it_s3.func == FUNC_EVAL);
			for (int k = 5; k <= NS; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// Hash front and weights
	always_ff @(posedge clk) begin
		if (en) begin
			it_s1    <= in_item;
			pz_s1[0] <= perm(in_item.cell_z);
			pz_s1[1] <= perm(in_item.cell_z + 1'b1);
			ff_s1[0] <= in_item.frac_x * in_item.frac_x;
			ff_s1[1] <= in_item.frac_y * in_item.frac_y;
			ff_s1[2] <= in_item.frac_z * in_item.frac_z;

			it_s2 <= it_s1;
			for (int k = 0; k < 4; k++) begin
				py_s2[k] <= perm(it_s1.cell_y + GN3_IDX_W'(k[0]) + pz_s1[k[1]]);
			end
			w_pipe_q[2] <= {w_c[2], w_c[1], w_c[0]};

			it_s3 <= it_s2;
			for (int c = 0; c < 8; c++) begin
				h_s3[c] <= perm(it_s2.cell_x + GN3_IDX_W'(c[0]) + py_s2[c[2:1]]);
			end

			it_s4 <= it_s3;
			for (int k = 3; k <= 13; k++) begin
				w_pipe_q[k] <= w_pipe_q[k-1];
			end
		end
	end

	// Gradient table, four copies with two read ports each
	assign wr_en = en && vld_q[3] && (it_s3.func == FUNC_LOAD);

	for (genvar k = 0; k < 4; k++) begin : g_mem
		logic [47:0] gmem [GN3_TABLE_SIZE];
		always_ff @(posedge clk) begin
			if (wr_en) begin
				gmem[it_s3.slot] <= {it_s3.gz, it_s3.gy, it_s3.gx};
			end
			if (en) begin
				g_s4[2*k]   <= gmem[h_s3[2*k]];
				g_s4[2*k+1] <= gmem[h_s3[2*k+1]];
			end
		end
	end

	// Corner products, dot sums, blend levels
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 8; c++) begin
				prod_s5[c][0] <= $signed(g_s4[c][15:0]) * $signed({c[0], it_s4.frac_x});
				prod_s5[c][1] <= $signed(g_s4[c][31:16]) * $signed({c[1], it_s4.frac_y});
				prod_s5[c][2] <= $signed(g_s4[c][47:32]) * $signed({c[2], it_s4.frac_z});
			end

			for (int c = 0; c < 8; c++) begin
				dot_s6[c] <= DW'(prod_s5[c][0]) + DW'(prod_s5[c][1]) + DW'(prod_s5[c][2]);
			end

			// x blend
			for (int k = 0; k < 4; k++) begin
				a_s7[k] <= dot_s6[2*k];
				d_s7[k] <= dot_s6[2*k+1] - dot_s6[2*k];
				a_s8[k] <= a_s7[k];
				m_s8[k] <= d_s7[k] * $signed({1'b0, w_pipe_q[7][0]});
				y_s9[k] <= a_s8[k] + m_s8[k][51:16];
			end

			// y blend
			for (int k = 0; k < 2; k++) begin
				a_s10[k] <= y_s9[2*k];
				d_s10[k] <= y_s9[2*k+1] - y_s9[2*k];
				a_s11[k] <= a_s10[k];
				m_s11[k] <= d_s10[k] * $signed({1'b0, w_pipe_q[10][1]});
				z_s12[k] <= a_s11[k] + m_s11[k][51:16];
			end

			// z blend
			a_s13 <= z_s12[0];
			d_s13 <= z_s12[1] - z_s12[0];
			a_s14 <= a_s13;
			m_s14 <= d_s13 * $signed({1'b0, w_pipe_q[13][2]});
			v_s15 <= a_s14 + m_s14[51:16];

			out_s16 <= rq > 20'sd32767 ? 16'h7FFF :
				(rq < -20'sd32768 ? 16'h8000 : rq[15:0]);
		end
	end

	// Round half up to Q1.15
	assign rnd = v_s15 + DW'(32768);
	assign rq  = rnd[DW-1:16];

endmodule

// File: bench/gradient_noise_3d_unit_tb.sv
// Self-checking testbench for the 3-D gradient noise unit.
`timescale 1ns / 100ps

module gradient_noise_3d_unit_tb;
	import gn3_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;

	logic          clk;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [151:0]  s_axis_tdata;   // x_coord, y_coord, z_coord, grad_slot, grad_x, grad_y, grad_z
	logic          s_axis_tuser;   // func
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [15:0]   m_axis_tdata;   // noise_value

	// Gradient table shadow, noise values still due, run status
	logic signed [15:0] grad_x_tab [GN3_TABLE_SIZE];
	logic signed [15:0] grad_y_tab [GN3_TABLE_SIZE];
	logic signed [15:0] grad_z_tab [GN3_TABLE_SIZE];
	logic [15:0]        noise_due [$];
	int                 err_count;
	int                 idle_cycles;
	int                 send_idle_pct;
	int                 recv_idle_pct;

	gradient_noise_3d_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hash of one lattice corner through the fixed permutation
	function automatic logic [7:0] corner_hash(logic [7:0] cx, logic [7:0] cy, logic [7:0] cz);
		logic [7:0] h;
		h = GN3_PERM[cz];
		h = GN3_PERM[8'(cy + h)];
		return GN3_PERM[8'(cx + h)];
	endfunction

	function automatic longint smoothstep_q16(longint f);
		return (f * f * (196608 - 2 * f)) >>> 32;
	endfunction

	function automatic longint lerp_q16(longint w, longint a, longint b);
		return a + ((w * (b - a)) >>> 16);
	endfunction

	// Expected noise for a Q16.16 point, from the shadow gradient table
	function automatic logic [15:0] noise_at(logic [31:0] xc, logic [31:0] yc, logic [31:0] zc);
		longint fx, fy, fz, wx, wy, wz, ox, oy, oz, v, r;
		longint dot [8];
		longint ex [4];
		longint ey [2];
		logic [7:0] h;
		int k;
		fx = longint'(xc[15:0]);
		fy = longint'(yc[15:0]);
		fz = longint'(zc[15:0]);
		// corner index: bit 0 x, bit 1 y, bit 2 z
		for (k = 0; k < 8; k++) begin
			h = corner_hash(8'(xc[23:16] + k[0]), 8'(yc[23:16] + k[1]), 8'(zc[23:16] + k[2]));
			ox = fx - (k[0] ? 65536 : 0);
			oy = fy - (k[1] ? 65536 : 0);
			oz = fz - (k[2] ? 65536 : 0);
			dot[k] = longint'(grad_x_tab[h]) * ox + longint'(grad_y_tab[h]) * oy
				+ longint'(grad_z_tab[h]) * oz;
		end
		wx = smoothstep_q16(fx);
		wy = smoothstep_q16(fy);
		wz = smoothstep_q16(fz);
		for (k = 0; k < 4; k++)
			ex[k] = lerp_q16(wx, dot[2*k], dot[2*k+1]);
		ey[0] = lerp_q16(wy, ex[0], ex[1]);
		ey[1] = lerp_q16(wy, ex[2], ex[3]);
		v = lerp_q16(wz, ey[0], ey[1]);
		r = (v + 32768) >>> 16;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	// Drive one word, wait for its handshake, then update the shadow state
	task automatic send_word(func_t fn, logic [31:0] xc, logic [31:0] yc, logic [31:0] zc,
			logic [7:0] slot, logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= fn;
		s_axis_tdata  <= {gz, gy, gx, slot, zc, yc, xc};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (fn == FUNC_LOAD) begin
			grad_x_tab[slot] = gx;
			grad_y_tab[slot] = gy;
			grad_z_tab[slot] = gz;
		end else begin
			noise_due.push_back(noise_at(xc, yc, zc));
		end
	endtask

	task automatic load_grad(logic [7:0] slot, logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
		send_word(FUNC_LOAD, $urandom, $urandom, $urandom, slot, gx, gy, gz);
	endtask

	task automatic eval_point(logic [31:0] xc, logic [31:0] yc, logic [31:0] zc);
		send_word(FUNC_EVAL, xc, yc, zc, 8'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	// Sender holds off until every noise value has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (noise_due.size() != 0)
			@(posedge clk);
	endtask

	// Fill every table entry so no evaluate reads an unloaded one
	task automatic test_table_fill();
		int i;
		load_grad(8'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		load_grad(8'd1, 16'h8000, 16'h8000, 16'h8000);
		load_grad(8'd2, 16'h7FFF, 16'h8000, 16'h0000);
		for (i = 3; i < GN3_TABLE_SIZE; i++)
			load_grad(8'(i), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// Coordinate extremes, lattice wrap, negative points
	task automatic test_coord_edges();
		eval_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		eval_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		eval_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		eval_point(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h8000_0000);
		eval_point(32'h00FF_8000, 32'h00FF_C000, 32'h00FF_0001);
		eval_point(32'hFFFF_8000, 32'hFFFE_4000, 32'hFF00_0000);
		eval_point(32'h0000_8000, 32'h0001_8000, 32'h0002_8000);
		eval_point(32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_F0F0);
		eval_point(32'h0100_0001, 32'h7F00_FFFE, 32'h8100_7FFF);
	endtask

	// Gradients aimed at (or, with neg, away from) the cube center from all eight corners overdrive Q1.15
	task automatic test_saturation(bit neg);
		logic [7:0] h;
		logic [15:0] gp, gn;
		int k;
		gp = neg ? 16'h8000 : 16'h7FFF;
		gn = neg ? 16'h7FFF : 16'h8000;
		for (k = 0; k < 8; k++) begin
			h = corner_hash(8'(5 + k[0]), 8'(9 + k[1]), 8'(3 + k[2]));
			load_grad(h, k[0] ? gn : gp, k[1] ? gn : gp, k[2] ? gn : gp);
		end
		eval_point(32'h0005_8000, 32'h0009_8000, 32'h0003_8000);
		eval_point(32'h0005_6000, 32'h0009_A000, 32'h0003_7000);
		wait_drained();
	endtask

	// Mostly evaluates at random points, a quarter of them near the lattice wrap, some table rewrites in between
	task automatic test_random_mix(int n_words);
		int i;
		for (i = 0; i < n_words; i++) begin
			if ($urandom_range(99) < 30)
				load_grad(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			else if ($urandom_range(3) == 0)
				eval_point({16'($urandom_range(3)), 16'($urandom)},
					{16'hFFFF - 16'($urandom_range(3)), 16'($urandom)},
					{16'($urandom_range(254, 257)), 16'($urandom)});
			else
				eval_point($urandom, $urandom, $urandom);
		end
		wait_drained();
	endtask

	// Receiver stalls at random
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// Result check and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (noise_due.size() == 0) begin
					$display("%0t: unexpected noise word, expected none, actual %h",
						$time, m_axis_tdata);
					err_count++;
				end else begin
					if (m_axis_tdata !== noise_due[0]) begin
						$display("%0t: noise_value mismatch, expected %h, actual %h",
							$time, noise_due[0], m_axis_tdata);
						err_count++;
					end
					void'(noise_due.pop_front());
				end
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int i;
		err_count = 0;
		idle_cycles = 0;
		send_idle_pct = 25;
		recv_idle_pct = 88;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tuser <= FUNC_EVAL;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		for (i = 0; i < 4; i++)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_fill();
		test_coord_edges();
		test_saturation(1'b0);
		test_saturation(1'b1);
		test_random_mix(90);
		send_idle_pct = 88;
		recv_idle_pct = 25;
		test_random_mix(90);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_mix(90);

		wait_drained();
		for (i = 0; i < DRAIN_CYCLES; i++)
			@(posedge clk);
		if (err_count == 0 && noise_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
